### rtl/start_end_marker_deframer_defines.svh
// assertion helpers shared by the deframer modules
`ifndef START_END_MARKER_DEFRAMER_DEFINES_SVH
`define START_END_MARKER_DEFRAMER_DEFINES_SVH

// condition that must hold at every edge out of reset
`define SMD_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger in this cycle implies the consequence in the next cycle
`define SMD_ASSERT_NEXT(name, clk, rst, trig, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/smd_pkg.sv
package smd_pkg;

   localparam int FRAME_LEN    = 16;
   localparam int BUFFER_LIMIT = 64;
   localparam int BYTE_W       = 8;
   localparam int CNT_W        = 7;
   localparam int CNT_MAX      = 127;
   localparam int IDX_W        = $clog2(FRAME_LEN);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = QPTR_W + 1;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] START_MARKER_RST = BYTE_W'(60);
   localparam logic [BYTE_W-1:0] END_MARKER_RST   = BYTE_W'(62);

   typedef enum logic {
      KIND_FRAME    = 1'b0,
      KIND_OVERFLOW = 1'b1
   } kind_type;

   // element 0 is the oldest byte
   typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      kind_type   kind;
      window_type bytes;
   } entry_type;

endpackage

### rtl/smd_front.sv
module smd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smd_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                              csr_valid,
   input  logic [smd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smd_pkg::BYTE_W-1:0]        csr_data,
   output logic                              push_valid,
   input  logic                              push_ready,
   output smd_pkg::entry_type                push_data
);

   logic [smd_pkg::BYTE_W-1:0] start_marker_ff, start_marker_in;
   logic [smd_pkg::BYTE_W-1:0] end_marker_ff, end_marker_in;
   smd_pkg::window_type        window_ff, window_in;
   logic [smd_pkg::CNT_W-1:0]  bse_ff, bse_in;
   logic [smd_pkg::CNT_W-1:0]  bss_ff, bss_in;
   logic                       seen_ff, seen_in;

   logic                       accept;
   logic [smd_pkg::CNT_W-1:0]  bse_n, bss_n;
   logic                       seen_n;
   logic                       hit_frame, hit_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= smd_pkg::START_MARKER_RST;
         end_marker_ff   <= smd_pkg::END_MARKER_RST;
         bse_ff          <= '0;
         bss_ff          <= '0;
         seen_ff         <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
         bse_ff          <= bse_in;
         bss_ff          <= bss_in;
         seen_ff         <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_valid) begin
         if (csr_index == smd_pkg::CSR_START_MARKER) begin
            start_marker_in = csr_data;
         end else if (csr_index == smd_pkg::CSR_END_MARKER) begin
            end_marker_in = csr_data;
         end
      end
   end

   always_comb begin
      req_tready = push_ready;
      accept     = req_tvalid && req_tready;

      bse_n = (bse_ff != smd_pkg::CNT_W'(smd_pkg::CNT_MAX)) ?
              bse_ff + smd_pkg::CNT_W'(1) : bse_ff;
      bss_n = (seen_ff && (bss_ff != smd_pkg::CNT_W'(smd_pkg::CNT_MAX))) ?
              bss_ff + smd_pkg::CNT_W'(1) : bss_ff;
      seen_n    = seen_ff;
      hit_frame = 1'b0;
      hit_ovf   = 1'b0;

      // latest start marker wins
      if (req_tdata == start_marker_ff) begin
         seen_n = 1'b1;
         bss_n  = smd_pkg::CNT_W'(1);
      end

      if (req_tdata == end_marker_ff) begin
         hit_frame = seen_n && (bss_n == smd_pkg::CNT_W'(smd_pkg::FRAME_LEN));
         bse_n     = '0;
         bss_n     = '0;
         seen_n    = 1'b0;
      end

      // checked after the end marker clear, so an end marker never overflows
      if (bse_n >= smd_pkg::CNT_W'(smd_pkg::BUFFER_LIMIT)) begin
         hit_ovf = 1'b1;
         bse_n   = '0;
         bss_n   = '0;
         seen_n  = 1'b0;
      end

      if (accept) begin
         window_in = {req_tdata, window_ff[smd_pkg::FRAME_LEN-1:1]};
         bse_in    = bse_n;
         bss_in    = bss_n;
         seen_in   = seen_n;
      end else begin
         window_in = window_ff;
         bse_in    = bse_ff;
         bss_in    = bss_ff;
         seen_in   = seen_ff;
      end

      push_valid      = req_tvalid && (hit_frame || hit_ovf);
      push_data.kind  = hit_ovf ? smd_pkg::KIND_OVERFLOW : smd_pkg::KIND_FRAME;
      push_data.bytes = {req_tdata, window_ff[smd_pkg::FRAME_LEN-1:1]};
   end

endmodule

### rtl/smd_fifo.sv
`include "start_end_marker_deframer_defines.svh"

module smd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  smd_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output smd_pkg::entry_type pop_data
);

   smd_pkg::entry_type               mem_ff [smd_pkg::QUEUE_DEPTH];
   logic [smd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [smd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [smd_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      push_ready = (count_ff != smd_pkg::QCNT_W'(smd_pkg::QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == smd_pkg::QPTR_W'(smd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + smd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == smd_pkg::QPTR_W'(smd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + smd_pkg::QPTR_W'(1);
      end

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + smd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - smd_pkg::QCNT_W'(1);
      end
   end

   `SMD_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= smd_pkg::QCNT_W'(smd_pkg::QUEUE_DEPTH), "queue count past depth")
   `SMD_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop,
      count_ff == $past(count_ff) + smd_pkg::QCNT_W'(1), "push did not grow queue")
   `SMD_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push,
      count_ff == $past(count_ff) - smd_pkg::QCNT_W'(1), "pop did not shrink queue")

endmodule

### rtl/smd_back.sv
`include "start_end_marker_deframer_defines.svh"

module smd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  smd_pkg::entry_type          pop_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [smd_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   smd_pkg::entry_type         ent_ff, ent_in;
   logic [smd_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       busy_ff, busy_in;
   logic                       beat, last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_comb begin
      last = (ent_ff.kind == smd_pkg::KIND_OVERFLOW) ||
             (idx_ff == smd_pkg::IDX_W'(smd_pkg::FRAME_LEN - 1));

      rsp_tvalid = busy_ff;
      rsp_tuser  = ent_ff.kind;
      rsp_tlast  = last;
      rsp_tdata  = (ent_ff.kind == smd_pkg::KIND_OVERFLOW) ? '0 : ent_ff.bytes[idx_ff];

      beat = rsp_tvalid && rsp_tready;
      // next entry loads on the beat that ends the current burst
      pop_ready = !busy_ff || (beat && last);

      ent_in  = ent_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop_ready && pop_valid) begin
         ent_in  = pop_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (beat) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + smd_pkg::IDX_W'(1);
         end
      end
   end

   `SMD_ASSERT_ALWAYS(a_idx_range, clock, reset,
      idx_ff <= smd_pkg::IDX_W'(smd_pkg::FRAME_LEN - 1), "burst index out of range")
   `SMD_ASSERT_ALWAYS(a_ovf_single, clock, reset,
      !(rsp_tvalid && rsp_tuser) || rsp_tlast, "overflow beat not marked last")
   `SMD_ASSERT_NEXT(a_burst_continues, clock, reset, beat && !last,
      rsp_tvalid && (idx_ff == $past(idx_ff) + smd_pkg::IDX_W'(1)), "frame burst broke off")

endmodule

### rtl/start_end_marker_deframer.sv
// start/end marker deframer
// req channel: one received byte per beat in req_tdata. a start marker byte
// marks a frame start (latest one wins); an end marker byte closes the run.
// when the span from start to end, both included, is exactly FRAME_LEN bytes,
// the whole frame goes out on the rsp channel as a burst of FRAME_LEN beats,
// tuser 0, tlast on the final byte. after BUFFER_LIMIT bytes without an end
// marker one overflow beat goes out (tuser 1, data 0, tlast 1).
// csr channel: index 0 start marker, index 1 end marker; other indexes are
// dropped. always ready; write only while the block is idle.
// throughput: one input byte per cycle while the two-entry burst queue has
// room. a burst's entry goes through the queue, then the back end's entry
// register; its bytes then go out one per cycle while rsp_tready is high,
// as the back end's byte index steps. a rsp stall holds the current beat;
// the front keeps taking bytes until the queue fills, then drops req_tready.
// reset: markers back to their defaults, counters and queue cleared.
module start_end_marker_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [smd_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] frame_byte
   output logic                              rsp_tuser,   // [0] result_kind
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smd_pkg::BYTE_W-1:0]        csr_data
);

   logic               push_valid, push_ready;
   smd_pkg::entry_type push_data;
   logic               pop_valid, pop_ready;
   smd_pkg::entry_type pop_data;

   assign csr_ready = 1'b1;

   smd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   smd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   smd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
